### src/http_request_byte_parser_defines.svh
// Assertion macros shared by the request parser modules.
`ifndef HTTP_REQUEST_BYTE_PARSER_DEFINES_SVH
`define HTTP_REQUEST_BYTE_PARSER_DEFINES_SVH
`ifndef SYNTH
`define HRBP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define HRBP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define HRBP_ASSERT(lbl, prop, msg)
`define HRBP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### src/hrbp_pkg.sv
// Types, constants and byte classification functions of the request parser.
package hrbp_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned ROLE_W     = 4;
	localparam int unsigned METHOD_W   = 3;
	localparam int unsigned VER_W      = 2;
	localparam int unsigned METHOD_N   = 5;
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [7:0] CH_HT    = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_QMARK = 8'h3F;

	typedef enum logic [ROLE_W-1:0] {
		ROLE_METHOD   = 4'd0,
		ROLE_PATH     = 4'd1,
		ROLE_QUERY    = 4'd2,
		ROLE_VERSION  = 4'd3,
		ROLE_NAME     = 4'd4,
		ROLE_VALUE    = 4'd5,
		ROLE_BODY     = 4'd6,
		ROLE_SEP      = 4'd7,
		ROLE_DROPPED  = 4'd8,
		ROLE_LINE_END = 4'd9
	} role_t;

	typedef enum logic [3:0] {
		PH_LINE = 4'b0001,
		PH_HDR  = 4'b0010,
		PH_BODY = 4'b0100,
		PH_FAIL = 4'b1000
	} phase_t;

	// Sections of the request line.
	localparam logic [1:0] SEC_METHOD  = 2'd0;
	localparam logic [1:0] SEC_PATH    = 2'd1;
	localparam logic [1:0] SEC_QUERY   = 2'd2;
	localparam logic [1:0] SEC_VERSION = 2'd3;
	// Sections of a header line.
	localparam logic [1:0] SEC_NAME    = 2'd0;
	localparam logic [1:0] SEC_LEAD    = 2'd1;
	localparam logic [1:0] SEC_VALUE   = 2'd2;

	localparam logic [METHOD_W-1:0] MC_NONE = 3'd0;
	localparam logic [VER_W-1:0] VER_NONE = 2'd0;
	localparam logic [VER_W-1:0] VER_1_0  = 2'd1;
	localparam logic [VER_W-1:0] VER_1_1  = 2'd2;

	localparam logic [METHOD_N-1:0] ALL_METHODS = '1;
	localparam logic [2:0] MLEN_MAX   = 3'd7;
	localparam logic [3:0] VPOS_MAX   = 4'd15;
	localparam logic [3:0] VPOS_DIGIT = 4'd7;
	localparam logic [3:0] VPOS_END   = 4'd8;
	localparam logic [7:0] SPACE_MAX  = 8'hFF;

	// GET, POST, HEAD, PUT, DELETE, padded with zero bytes.
	localparam logic [7:0] METH_NAME [METHOD_N][8] = '{
		'{8'h47, 8'h45, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h50, 8'h4F, 8'h53, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h48, 8'h45, 8'h41, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h50, 8'h55, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h44, 8'h45, 8'h4C, 8'h45, 8'h54, 8'h45, 8'h00, 8'h00}
	};
	localparam logic [2:0] METH_LEN [METHOD_N] = '{3'd3, 3'd4, 3'd4, 3'd3, 3'd6};

	// "HTTP/1." followed by a zero byte that is never compared.
	localparam logic [7:0] VER_PREFIX [8] = '{
		8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E, 8'h00
	};

	typedef struct packed {
		phase_t               phase;
		logic [1:0]           section;
		logic                 cr_pending;
		logic [METHOD_N-1:0]  cand;
		logic [2:0]           mlen;
		logic [3:0]           vpos;
		logic                 vmatch;
		logic [1:0]           vdigit;
		logic [7:0]           space_run;
	} parse_state_t;

	typedef struct packed {
		logic [BYTE_W-1:0]   out_byte;
		role_t               role;
		logic [METHOD_W-1:0] method_code;
		logic [VER_W-1:0]    http_version;
		logic                line_ok;
		logic                headers_done;
		logic [7:0]          trailing_space;
		logic                last_result;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

	typedef struct packed {
		parse_state_t st;
		role_t        role;
	} content_t;

	typedef struct packed {
		parse_state_t st;
		result_t      res;
	} line_close_t;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == CH_SP) || ((b >= CH_HT) && (b <= CH_CR));
	endfunction

	function automatic parse_state_t fresh_line(input phase_t ph);
		parse_state_t s;
		s.phase      = ph;
		s.section    = SEC_METHOD;
		s.cr_pending = 1'b0;
		s.cand       = ALL_METHODS;
		s.mlen       = '0;
		s.vpos       = '0;
		s.vmatch     = 1'b1;
		s.vdigit     = VER_NONE;
		s.space_run  = '0;
		return s;
	endfunction

	function automatic result_t make_result(input logic [7:0] b, input role_t role);
		result_t r;
		r                = '0;
		r.out_byte       = b;
		r.role           = role;
		return r;
	endfunction

	// Classifies one content byte of the request line or of a header line.
	function automatic content_t content_step(input parse_state_t st, input logic [7:0] b);
		content_t c;
		c.st   = st;
		c.role = ROLE_DROPPED;
		if (st.phase == PH_HDR) begin
			unique case (st.section)
				SEC_NAME: begin
					if (b == CH_COLON) begin
						c.st.section = SEC_LEAD;
						c.role       = ROLE_SEP;
					end else begin
						c.role = ROLE_NAME;
					end
				end
				SEC_LEAD: begin
					if (is_ws(b)) begin
						c.role = ROLE_SEP;
					end else begin
						c.st.section   = SEC_VALUE;
						c.st.space_run = '0;
						c.role         = ROLE_VALUE;
					end
				end
				default: begin
					if (!is_ws(b))
						c.st.space_run = '0;
					else if (st.space_run != SPACE_MAX)
						c.st.space_run = st.space_run + 8'd1;
					c.role = ROLE_VALUE;
				end
			endcase
		end else begin
			unique case (st.section)
				SEC_METHOD: begin
					if (b == CH_SP) begin
						for (int i = 0; i < METHOD_N; i++)
							if (METH_LEN[i] != st.mlen)
								c.st.cand[i] = 1'b0;
						c.st.section = SEC_PATH;
						c.role       = ROLE_SEP;
					end else begin
						for (int i = 0; i < METHOD_N; i++)
							if ((st.mlen >= METH_LEN[i]) || (METH_NAME[i][st.mlen] != b))
								c.st.cand[i] = 1'b0;
						if (st.mlen != MLEN_MAX)
							c.st.mlen = st.mlen + 3'd1;
						c.role = ROLE_METHOD;
					end
				end
				SEC_PATH: begin
					if (b == CH_SP) begin
						c.st.section = SEC_VERSION;
						c.role       = ROLE_SEP;
					end else if (b == CH_QMARK) begin
						c.st.section = SEC_QUERY;
						c.role       = ROLE_QUERY;
					end else begin
						c.role = ROLE_PATH;
					end
				end
				SEC_QUERY: begin
					if (b == CH_SP) begin
						c.st.section = SEC_VERSION;
						c.role       = ROLE_SEP;
					end else begin
						c.role = ROLE_QUERY;
					end
				end
				default: begin
					if (st.vpos < VPOS_DIGIT) begin
						if (VER_PREFIX[st.vpos[2:0]] != b)
							c.st.vmatch = 1'b0;
					end else if (st.vpos == VPOS_DIGIT) begin
						if (b == CH_ONE)
							c.st.vdigit = VER_1_1;
						else if (b == CH_ZERO)
							c.st.vdigit = VER_1_0;
						else
							c.st.vmatch = 1'b0;
					end else begin
						c.st.vmatch = 1'b0;
					end
					if (st.vpos != VPOS_MAX)
						c.st.vpos = st.vpos + 4'd1;
					c.role = ROLE_VERSION;
				end
			endcase
		end
		return c;
	endfunction

	// Builds the line end result and moves on to the next phase.
	function automatic line_close_t line_close(input parse_state_t st);
		line_close_t         lc;
		logic                colon;
		logic [METHOD_W-1:0] mc;
		logic [VER_W-1:0]    ver;
		logic                ok;
		lc.res      = make_result(8'h00, ROLE_LINE_END);
		colon       = (st.section != SEC_NAME);
		mc          = MC_NONE;
		ver         = VER_NONE;
		if (st.phase == PH_HDR) begin
			lc.res.line_ok        = colon;
			lc.res.headers_done   = !colon;
			lc.res.trailing_space = colon ? st.space_run : 8'h00;
			lc.st = fresh_line(colon ? PH_HDR : PH_BODY);
		end else begin
			if (st.section != SEC_METHOD)
				for (int i = METHOD_N - 1; i >= 0; i--)
					if (st.cand[i])
						mc = METHOD_W'(i + 1);
			if ((st.section == SEC_VERSION) && st.vmatch && (st.vpos == VPOS_END))
				ver = st.vdigit;
			ok = (mc != MC_NONE) && (ver != VER_NONE);
			lc.res.method_code  = mc;
			lc.res.http_version = ver;
			lc.res.line_ok      = ok;
			lc.st = fresh_line(ok ? PH_HDR : PH_FAIL);
		end
		return lc;
	endfunction

endpackage

### src/hrbp_stream_if.sv
// Byte stream channel into the request parser.
interface hrbp_stream_if;
	import hrbp_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              new_request;

	modport source (output valid, output data_byte, output new_request, input ready);
	modport sink (input valid, input data_byte, input new_request, output ready);
endinterface

### src/hrbp_result_if.sv
// Classified byte channel out of the request parser.
interface hrbp_result_if;
	import hrbp_pkg::*;

	logic                valid;
	logic                ready;
	logic [BYTE_W-1:0]   out_byte;
	logic [ROLE_W-1:0]   role;
	logic [METHOD_W-1:0] method_code;
	logic [VER_W-1:0]    http_version;
	logic                line_ok;
	logic                headers_done;
	logic [7:0]          trailing_space;
	logic                last_result;

	modport source (
		output valid, output out_byte, output role, output method_code,
		output http_version, output line_ok, output headers_done,
		output trailing_space, output last_result, input ready
	);
	modport sink (
		input valid, input out_byte, input role, input method_code,
		input http_version, input line_ok, input headers_done,
		input trailing_space, input last_result, output ready
	);
endinterface

### src/hrbp_classifier.sv
// Parse state register and the per-byte classification step.
`include "http_request_byte_parser_defines.svh"

module hrbp_classifier (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [7:0]        data_byte,
	input  logic              new_request,
	output hrbp_pkg::push_t   push
);
	import hrbp_pkg::*;

	parse_state_t state_q;
	parse_state_t st;
	parse_state_t cur;
	content_t     c_cr;
	content_t     c_b;
	line_close_t  lc;
	result_t      first;
	result_t      second;
	result_t      r_b;
	logic [1:0]   n;
	logic         lf_done;

	always_comb begin
		st      = new_request ? fresh_line(PH_LINE) : state_q;
		cur     = st;
		first   = '0;
		second  = '0;
		r_b     = '0;
		n       = 2'd0;
		lf_done = 1'b0;
		c_cr    = '0;
		c_b     = '0;
		lc      = '0;
		unique case (st.phase)
			PH_BODY: begin
				first = make_result(data_byte, ROLE_BODY);
				n     = 2'd1;
			end
			PH_FAIL: begin
				first = make_result(data_byte, ROLE_DROPPED);
				n     = 2'd1;
			end
			PH_LINE, PH_HDR: begin
				// A held CR either closes the line or goes out as content first.
				if (cur.cr_pending) begin
					cur.cr_pending = 1'b0;
					if (data_byte == CH_LF) begin
						lc      = line_close(cur);
						first   = lc.res;
						cur     = lc.st;
						n       = 2'd1;
						lf_done = 1'b1;
					end else begin
						c_cr  = content_step(cur, CH_CR);
						first = make_result(CH_CR, c_cr.role);
						cur   = c_cr.st;
						n     = 2'd1;
					end
				end
				if (!lf_done) begin
					if (data_byte == CH_CR) begin
						cur.cr_pending = 1'b1;
					end else begin
						c_b = content_step(cur, data_byte);
						r_b = make_result(data_byte, c_b.role);
						cur = c_b.st;
						if (n == 2'd0)
							first = r_b;
						else
							second = r_b;
						n = n + 2'd1;
					end
				end
			end
			default: begin
				cur = fresh_line(PH_LINE);
			end
		endcase
		if (n == 2'd1)
			first.last_result = 1'b1;
		if (n == 2'd2)
			second.last_result = 1'b1;
		push.count  = fire ? n : 2'd0;
		push.first  = first;
		push.second = second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fresh_line(PH_LINE);
		end else if (fire) begin
			state_q <= cur;
		end
	end

	`HRBP_ASSERT(a_two_needs_cr, (!fire || push.count != 2'd2) || (state_q.cr_pending && !new_request), "two results without a held CR")
	`HRBP_ASSERT_NEXT(a_none_holds_cr, fire && (push.count == 2'd0), state_q.cr_pending, "byte without result did not hold a CR")

endmodule

### src/hrbp_result_fifo.sv
// Four-entry result queue that takes up to two results a cycle.
`include "http_request_byte_parser_defines.svh"

module hrbp_result_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  hrbp_pkg::push_t push,
	output logic            room,
	hrbp_result_if.source   result
);
	import hrbp_pkg::*;

	localparam int unsigned CNT_W = FIFO_AW + 1;

	result_t            mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic [FIFO_AW-1:0] wr_ptr_nx;
	logic               pop;
	result_t            head;

	assign pop       = result.valid && result.ready;
	assign wr_ptr_nx = wr_ptr_q + FIFO_AW'(1);
	// Space is reserved for the worst case of two results from one byte.
	assign room      = (count_q <= CNT_W'(FIFO_DEPTH - 2));
	assign head      = mem_q[rd_ptr_q];

	assign result.valid          = (count_q != '0);
	assign result.out_byte       = head.out_byte;
	assign result.role           = head.role;
	assign result.method_code    = head.method_code;
	assign result.http_version   = head.http_version;
	assign result.line_ok        = head.line_ok;
	assign result.headers_done   = head.headers_done;
	assign result.trailing_space = head.trailing_space;
	assign result.last_result    = head.last_result;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			mem_q[wr_ptr_q] <= push.first;
		if (push.count == 2'd2)
			mem_q[wr_ptr_nx] <= push.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push.count);
			if (pop)
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			count_q <= count_q + CNT_W'(push.count) - CNT_W'(pop);
		end
	end

	`HRBP_ASSERT(a_no_overflow, count_q <= CNT_W'(FIFO_DEPTH), "result queue overflow")
	`HRBP_ASSERT(a_push_has_room, (push.count == 2'd0) || room, "results pushed without reserved room")

endmodule

### src/http_request_byte_parser.sv
// HTTP/1.0 and HTTP/1.1 request line and header byte parser: the top level.
//
// The stream channel carries one raw request byte per transaction, with
// new_request set on the first byte of a request to restart parsing. The
// result channel carries one classified byte or line end verdict per
// transaction; last_result marks the final result caused by an input byte.
// A byte can cause no result (a CR held back until the next byte), one
// result, or two (a held CR passed on as content ahead of the next byte).
// A byte waits in the input register until the step fires; its results are
// written into the queue together, and a second one is offered after the first.
// A byte is accepted every cycle while the queue has two free entries: the
// input register hands its byte to the classification step as the next one
// arrives, and the step's state update is combinational logic.
// Results wait in a four-entry queue; the step fires only when two entries
// are free, so a stalled receiver fills the queue and then holds off the
// stream channel without losing or repeating anything.
// Reset empties the input register and the queue and returns the parser to
// the start of a request line.
module http_request_byte_parser (
	input  logic          clk,
	input  logic          arst_n,
	hrbp_stream_if.sink   stream,
	hrbp_result_if.source result
);
	import hrbp_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] data_byte_s1;
	logic              new_request_s1;
	logic              room;
	logic              fire;
	push_t             push;

	assign fire         = valid_s1 && room;
	assign stream.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			data_byte_s1   <= stream.data_byte;
			new_request_s1 <= stream.new_request;
		end
	end

	hrbp_classifier u_classifier (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.data_byte   (data_byte_s1),
		.new_request (new_request_s1),
		.push        (push)
	);

	hrbp_result_fifo u_result_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.result (result)
	);

endmodule

### sim/http_request_byte_parser_tb.sv
// Self-checking testbench for the HTTP request line and header byte parser.
`timescale 1ns / 100ps

module http_request_byte_parser_tb;
	import hrbp_pkg::*;

	typedef enum logic [METHOD_W-1:0] {
		MC_INVALID = 3'd0,
		MC_GET     = 3'd1,
		MC_POST    = 3'd2,
		MC_HEAD    = 3'd3,
		MC_PUT     = 3'd4,
		MC_DELETE  = 3'd5
	} method_code_t;

	typedef enum int unsigned {
		RX_STEADY,
		RX_EVERY_THIRD,
		RX_COIN,
		RX_SLOW
	} rx_mode_t;

	// One byte of stimulus. Where check is set the expectation is written in the row;
	// otherwise it comes from the predictor and the remaining fields are unused.
	typedef struct packed {
		logic [7:0]   data;
		logic         restart;
		logic         check;
		role_t        role;
		method_code_t mc;
		logic [1:0]   ver;
		logic         ok;
		logic         done;
		logic [7:0]   trail;
	} step_row_t;

	localparam int DIRECTED_N   = 31;
	localparam int STREAM_BYTES = 430;

	step_row_t directed_rows [DIRECTED_N] = '{
		'{8'h50, 1'b1, 1'b1, ROLE_METHOD,   MC_INVALID, VER_NONE, 1'b0, 1'b0, 8'd0},
		'{8'h55, 1'b0, 1'b0, ROLE_METHOD,   MC_INVALID, VER_NONE, 1'b0, 1'b0, 8'd0},
		'{8'h54, 1'b0, 1'b0, ROLE_METHOD,   MC_INVALID, VER_NONE, 1'b0, 1'b0, 8'd0},
		'{8'h20, 1'b0, 1'b0, ROLE_METHOD,   MC_INVALID, VER_NONE, 1'b0, 1'b0, 8'd0},
		'{8'h3F, 1'b0, 1'b0, ROLE_METHOD,   MC_INVALID, VER_NONE, 1'b0, 1'b0, 8'd0},
		'{8'h20, 1'b0, 1'b0, ROLE_METHOD,   MC_INVALID, VER_NONE, 1'b0, 1'b0, 8'd0},
		'{8'h48, 1'b0, 1'b0, ROLE_METHOD,   MC_INVALID, VER_NONE, 1'b0, 1'b0, 8'd0},
		'{8'h54, 1'b0, 1'b0, ROLE_METHOD,   MC_INVALID, VER_NONE, 1'b0, 1'b0, 8'd0},
		'{8'h54, 1'b0, 1'b0, ROLE_METHOD,   MC_INVALID, VER_NONE, 1'b0, 1'b0, 8'd0},
		'{8'h50, 1'b0, 1'b0, ROLE_METHOD,   MC_INVALID, VER_NONE, 1'b0, 1'b0, 8'd0},
		'{8'h2F, 1'b0, 1'b0, ROLE_METHOD,   MC_INVALID, VER_NONE, 1'b0, 1'b0, 8'd0},
		'{8'h31, 1'b0, 1'b0, ROLE_METHOD,   MC_INVALID, VER_NONE, 1'b0, 1'b0, 8'd0},
		'{8'h2E, 1'b0, 1'b0, ROLE_METHOD,   MC_INVALID, VER_NONE, 1'b0, 1'b0, 8'd0},
		'{8'h30, 1'b0, 1'b0, ROLE_METHOD,   MC_INVALID, VER_NONE, 1'b0, 1'b0, 8'd0},
		'{8'h0D, 1'b0, 1'b0, ROLE_METHOD,   MC_INVALID, VER_NONE, 1'b0, 1'b0, 8'd0},
		'{8'h0A, 1'b0, 1'b1, ROLE_LINE_END, MC_PUT,     VER_1_0,  1'b1, 1'b0, 8'd0},
		'{8'h3A, 1'b0, 1'b0, ROLE_METHOD,   MC_INVALID, VER_NONE, 1'b0, 1'b0, 8'd0},
		'{8'hFF, 1'b0, 1'b1, ROLE_VALUE,    MC_INVALID, VER_NONE, 1'b0, 1'b0, 8'd0},
		'{8'h20, 1'b0, 1'b0, ROLE_METHOD,   MC_INVALID, VER_NONE, 1'b0, 1'b0, 8'd0},
		'{8'h0D, 1'b0, 1'b0, ROLE_METHOD,   MC_INVALID, VER_NONE, 1'b0, 1'b0, 8'd0},
		'{8'h00, 1'b0, 1'b0, ROLE_METHOD,   MC_INVALID, VER_NONE, 1'b0, 1'b0, 8'd0},
		'{8'h0D, 1'b0, 1'b0, ROLE_METHOD,   MC_INVALID, VER_NONE, 1'b0, 1'b0, 8'd0},
		'{8'h0A, 1'b0, 1'b1, ROLE_LINE_END, MC_INVALID, VER_NONE, 1'b1, 1'b0, 8'd0},
		'{8'h78, 1'b0, 1'b0, ROLE_METHOD,   MC_INVALID, VER_NONE, 1'b0, 1'b0, 8'd0},
		'{8'h0D, 1'b0, 1'b0, ROLE_METHOD,   MC_INVALID, VER_NONE, 1'b0, 1'b0, 8'd0},
		'{8'h0A, 1'b0, 1'b1, ROLE_LINE_END, MC_INVALID, VER_NONE, 1'b0, 1'b1, 8'd0},
		'{8'hFF, 1'b0, 1'b1, ROLE_BODY,     MC_INVALID, VER_NONE, 1'b0, 1'b0, 8'd0},
		'{8'h00, 1'b1, 1'b1, ROLE_METHOD,   MC_INVALID, VER_NONE, 1'b0, 1'b0, 8'd0},
		'{8'h0D, 1'b0, 1'b0, ROLE_METHOD,   MC_INVALID, VER_NONE, 1'b0, 1'b0, 8'd0},
		'{8'h0A, 1'b0, 1'b1, ROLE_LINE_END, MC_INVALID, VER_NONE, 1'b0, 1'b0, 8'd0},
		'{8'h0D, 1'b0, 1'b1, ROLE_DROPPED,  MC_INVALID, VER_NONE, 1'b0, 1'b0, 8'd0}
	};

	string method_word [METHOD_N] = '{"GET", "POST", "HEAD", "PUT", "DELETE"};
	string version_head = "HTTP/1.";

	logic clk;
	logic arst_n;

	hrbp_stream_if stream_ch ();
	hrbp_result_if result_ch ();

	http_request_byte_parser DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_ch),
		.result (result_ch)
	);

	step_row_t   byte_stream [$];
	result_t     pending_results [$];
	int unsigned bytes_taken = 0;
	int unsigned mismatches = 0;

	// Parser state as the predictor sees it.
	phase_t              cur_phase;
	logic [1:0]          cur_section;
	logic                cr_held;
	logic [METHOD_N-1:0] methods_left;
	logic [2:0]          method_len;
	logic [3:0]          version_pos;
	logic                version_ok;
	logic [1:0]          version_digit;
	logic [7:0]          blank_run;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#3ms;
		$display("http_request_byte_parser test failed");
		$finish;
	end

	function automatic logic is_blank(input logic [7:0] b);
		return (b == CH_SP) || (b >= CH_HT && b <= CH_CR);
	endfunction

	function automatic void start_line();
		cur_section   = SEC_METHOD;
		cr_held       = 1'b0;
		methods_left  = ALL_METHODS;
		method_len    = '0;
		version_pos   = '0;
		version_ok    = 1'b1;
		version_digit = VER_NONE;
		blank_run     = '0;
	endfunction

	function automatic result_t tagged_byte(input logic [7:0] b, input role_t role);
		result_t r;
		r          = '0;
		r.out_byte = b;
		r.role     = role;
		return r;
	endfunction

	function automatic role_t classify_byte(input logic [7:0] b);
		if (cur_phase == PH_HDR) begin
			if (cur_section == SEC_NAME) begin
				if (b != CH_COLON)
					return ROLE_NAME;
				cur_section = SEC_LEAD;
				return ROLE_SEP;
			end
			// Blanks straight after the colon are separators and do not count.
			if (cur_section == SEC_LEAD) begin
				if (is_blank(b))
					return ROLE_SEP;
				cur_section = SEC_VALUE;
			end
			if (!is_blank(b))
				blank_run = '0;
			else if (blank_run != SPACE_MAX)
				blank_run++;
			return ROLE_VALUE;
		end
		case (cur_section)
			SEC_METHOD: begin
				if (b == CH_SP) begin
					for (int i = 0; i < METHOD_N; i++)
						if (method_word[i].len() != method_len)
							methods_left[i] = 1'b0;
					cur_section = SEC_PATH;
					return ROLE_SEP;
				end
				for (int i = 0; i < METHOD_N; i++)
					if (method_len >= method_word[i].len() || method_word[i][method_len] != b)
						methods_left[i] = 1'b0;
				if (method_len != MLEN_MAX)
					method_len++;
				return ROLE_METHOD;
			end
			SEC_PATH: begin
				if (b == CH_SP) begin
					cur_section = SEC_VERSION;
					return ROLE_SEP;
				end
				if (b == CH_QMARK) begin
					cur_section = SEC_QUERY;
					return ROLE_QUERY;
				end
				return ROLE_PATH;
			end
			SEC_QUERY: begin
				if (b == CH_SP) begin
					cur_section = SEC_VERSION;
					return ROLE_SEP;
				end
				return ROLE_QUERY;
			end
			default: begin
				if (version_pos < VPOS_DIGIT) begin
					if (version_head[version_pos] != b)
						version_ok = 1'b0;
				end else if (version_pos == VPOS_DIGIT) begin
					if (b == CH_ONE)
						version_digit = VER_1_1;
					else if (b == CH_ZERO)
						version_digit = VER_1_0;
					else
						version_ok = 1'b0;
				end else begin
					version_ok = 1'b0;
				end
				if (version_pos != VPOS_MAX)
					version_pos++;
				return ROLE_VERSION;
			end
		endcase
	endfunction

	function automatic result_t close_line();
		result_t             r;
		logic [METHOD_W-1:0] mc;
		r      = '0;
		r.role = ROLE_LINE_END;
		mc     = MC_NONE;
		if (cur_phase == PH_HDR) begin
			if (cur_section == SEC_NAME) begin
				r.headers_done = 1'b1;
				cur_phase      = PH_BODY;
			end else begin
				r.line_ok        = 1'b1;
				r.trailing_space = blank_run;
			end
		end else begin
			// The lowest code still in the running wins.
			if (cur_section != SEC_METHOD)
				for (int i = 0; i < METHOD_N; i++)
					if (methods_left[i] && mc == MC_NONE)
						mc = METHOD_W'(i + 1);
			r.method_code = mc;
			if (cur_section == SEC_VERSION && version_ok && version_pos == VPOS_END)
				r.http_version = version_digit;
			r.line_ok = (mc != MC_NONE) && (r.http_version != VER_NONE);
			cur_phase = r.line_ok ? PH_HDR : PH_FAIL;
		end
		start_line();
		return r;
	endfunction

	// Works out the results of one accepted byte and queues them when asked to.
	task automatic parse_byte(input logic [7:0] b, input logic restart, input bit record);
		result_t fresh [$];
		bit      line_closed;
		line_closed = 1'b0;
		if (restart) begin
			cur_phase = PH_LINE;
			start_line();
		end
		if (cur_phase == PH_BODY) begin
			fresh.push_back(tagged_byte(b, ROLE_BODY));
		end else if (cur_phase == PH_FAIL) begin
			fresh.push_back(tagged_byte(b, ROLE_DROPPED));
		end else begin
			if (cr_held) begin
				cr_held = 1'b0;
				if (b == CH_LF) begin
					fresh.push_back(close_line());
					line_closed = 1'b1;
				end else begin
					fresh.push_back(tagged_byte(CH_CR, classify_byte(CH_CR)));
				end
			end
			if (!line_closed) begin
				if (b == CH_CR)
					cr_held = 1'b1;
				else
					fresh.push_back(tagged_byte(b, classify_byte(b)));
			end
		end
		if (fresh.size() != 0)
			fresh[$].last_result = 1'b1;
		if (record)
			foreach (fresh[k])
				pending_results.push_back(fresh[k]);
	endtask

	function automatic void push_byte(input logic [7:0] b, input logic restart = 1'b0);
		step_row_t s;
		s         = '0;
		s.data    = b;
		s.restart = restart;
		byte_stream.push_back(s);
	endfunction

	function automatic void push_text(input string t);
		for (int k = 0; k < t.len(); k++)
			push_byte(t[k]);
	endfunction

	function automatic void end_line();
		push_byte(CH_CR);
		push_byte(CH_LF);
	endfunction

	function automatic logic [7:0] text_char();
		return 8'($urandom_range(8'h21, 8'h7E));
	endfunction

	function automatic logic [7:0] blank_char();
		return $urandom_range(0, 1) ? CH_SP : CH_HT;
	endfunction

	// A request with random content; a few are malformed or cut short.
	function automatic void add_request(input bit long_blanks);
		int unsigned start_idx;
		int unsigned kind;
		start_idx = byte_stream.size();
		kind      = $urandom_range(0, 15);
		if (kind == 0)
			repeat ($urandom_range(1, 10)) push_byte(8'($urandom_range(0, 255)));
		else
			push_text(method_word[$urandom_range(0, METHOD_N - 1)]);
		byte_stream[start_idx].restart = 1'b1;
		push_byte(CH_SP);
		push_text("/");
		repeat ($urandom_range(0, 6)) push_byte(text_char());
		if ($urandom_range(0, 2) == 0) begin
			push_byte(CH_QMARK);
			repeat ($urandom_range(0, 5)) push_byte(text_char());
		end
		push_byte(CH_SP);
		case (kind)
			1: repeat ($urandom_range(1, 18)) push_byte(text_char());
			2: begin
				push_text("HTTP/1.");
				push_byte(8'($urandom_range(8'h32, 8'h39)));
			end
			4: push_text("HTTP/1.1 ");
			default: push_text($urandom_range(0, 1) ? "HTTP/1.1" : "HTTP/1.0");
		endcase
		if (kind == 3) begin
			// Cut off before the line end, sometimes with a CR still held back.
			if ($urandom_range(0, 1))
				push_byte(CH_CR);
			return;
		end
		end_line();
		repeat ($urandom_range(0, 3)) begin
			repeat ($urandom_range(1, 6)) push_byte(text_char());
			if ($urandom_range(0, 9) != 0)
				push_byte(CH_COLON);
			repeat ($urandom_range(0, 2)) push_byte(blank_char());
			repeat ($urandom_range(0, 6)) push_byte(text_char());
			if ($urandom_range(0, 5) == 0)
				push_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
			repeat ($urandom_range(0, 3)) push_byte(blank_char());
			end_line();
		end
		// Enough trailing blanks to saturate the count.
		if (long_blanks) begin
			push_text("Pad:v");
			repeat (260) push_byte(CH_SP);
			end_line();
		end
		if ($urandom_range(0, 3) == 0)
			push_text("eoh");
		end_line();
		repeat ($urandom_range(0, 8)) push_byte(8'($urandom_range(0, 255)));
	endfunction

	task automatic check_field(input string field, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
		end
	endtask

	// Each result transaction is matched against the oldest expectation.
	always @(posedge clk) begin : watch_results
		result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result: expected none, actual byte %0d role %0d",
					$time, result_ch.out_byte, result_ch.role);
			end else begin
				want = pending_results.pop_front();
				check_field("out_byte", want.out_byte, result_ch.out_byte);
				check_field("role", want.role, result_ch.role);
				check_field("method_code", want.method_code, result_ch.method_code);
				check_field("http_version", want.http_version, result_ch.http_version);
				check_field("line_ok", want.line_ok, result_ch.line_ok);
				check_field("headers_done", want.headers_done, result_ch.headers_done);
				check_field("trailing_space", want.trailing_space, result_ch.trailing_space);
				check_field("last_result", want.last_result, result_ch.last_result);
			end
		end
	end

	initial begin
		rx_mode_t mode;
		int unsigned span;
		bit held_off;
		held_off = 1'b0;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			// One long hold-off so that the result queue fills and the byte stream stalls.
			if (!held_off && bytes_taken >= 60) begin
				held_off = 1'b1;
				result_ch.ready <= 1'b0;
				repeat (200) @(posedge clk);
			end
			mode = rx_mode_t'($urandom_range(0, 3));
			span = $urandom_range(16, 96);
			for (int n = 0; n < span; n++) begin
				case (mode)
					RX_STEADY:      result_ch.ready <= 1'b1;
					RX_EVERY_THIRD: result_ch.ready <= (n % 3) != 2;
					RX_COIN:        result_ch.ready <= $urandom_range(0, 1);
					default:        result_ch.ready <= $urandom_range(0, 3) == 0;
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin
		step_row_t   cur;
		result_t     fixed_res;
		int unsigned idx;
		int unsigned burst;
		int unsigned gap;
		int unsigned stop_at;
		int unsigned idle_wait;

		stream_ch.valid       <= 1'b0;
		stream_ch.data_byte   <= '0;
		stream_ch.new_request <= 1'b0;
		cur_phase = PH_LINE;
		start_line();

		foreach (directed_rows[k])
			byte_stream.push_back(directed_rows[k]);
		add_request(1'b1);
		stop_at = STREAM_BYTES;
		while (byte_stream.size() < stop_at) begin
			if ($urandom_range(0, 5) == 0)
				repeat ($urandom_range(1, 8))
					push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
			else
				add_request(1'b0);
		end

		wait (arst_n === 1'b1);
		@(posedge clk);
		idx = 0;
		while (idx < byte_stream.size()) begin
			burst = $urandom_range(1, 24);
			gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
			for (int k = 0; k < burst && idx < byte_stream.size(); k++) begin
				cur = byte_stream[idx];
				stream_ch.valid       <= 1'b1;
				stream_ch.data_byte   <= cur.data;
				stream_ch.new_request <= cur.restart;
				@(posedge clk);
				while (!stream_ch.ready)
					@(posedge clk);
				// The predictor always runs so that its state follows the block.
				parse_byte(cur.data, cur.restart, !cur.check);
				if (cur.check) begin
					fixed_res                = '0;
					fixed_res.out_byte       = (cur.role == ROLE_LINE_END) ? 8'h00 : cur.data;
					fixed_res.role           = cur.role;
					fixed_res.method_code    = cur.mc;
					fixed_res.http_version   = cur.ver;
					fixed_res.line_ok        = cur.ok;
					fixed_res.headers_done   = cur.done;
					fixed_res.trailing_space = cur.trail;
					fixed_res.last_result    = 1'b1;
					pending_results.push_back(fixed_res);
				end
				bytes_taken++;
				idx++;
			end
			if (gap != 0) begin
				stream_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		stream_ch.valid <= 1'b0;

		idle_wait = 0;
		while (pending_results.size() != 0 && idle_wait < 20000) begin
			@(posedge clk);
			idle_wait++;
		end
		repeat (20) @(posedge clk);
		if (pending_results.size() != 0)
			$display("%0t: %0d expected results never arrived", $time, pending_results.size());
		if (mismatches == 0 && pending_results.size() == 0)
			$display("http_request_byte_parser test passed");
		else
			$display("http_request_byte_parser test failed");
		$finish;
	end

endmodule

### files.f
+incdir+src
src/hrbp_pkg.sv
src/hrbp_stream_if.sv
src/hrbp_result_if.sv
src/hrbp_classifier.sv
src/hrbp_result_fifo.sv
src/http_request_byte_parser.sv
sim/http_request_byte_parser_tb.sv
